FILE: design/mbd_pkg.sv
// ----------------------------------------------------------------------------
// mbd_pkg
// Shared constants and types for the mipmap 2x2 box downsampler.
// ----------------------------------------------------------------------------
package mbd_pkg;

   localparam int MaxSizeLog2 = 10;
   localparam int StoreDepth  = 1 << MaxSizeLog2;
   localparam int AddrW       = MaxSizeLog2;
   localparam int LvW         = 4;
   localparam int PosW        = MaxSizeLog2;
   localparam int SumW        = 10;
   localparam int EntryW      = 4 * SumW;
   localparam int NumLevels   = MaxSizeLog2 + 1;

   localparam logic [0:0] CsrSize  = 1'b0;
   localparam logic [0:0] CsrChans = 1'b1;

   typedef logic [SumW-1:0] sum_type [4];

endpackage

FILE: design/mbd_row_ram.sv
// ----------------------------------------------------------------------------
// mbd_row_ram
// Row store of partial 2x2 sums, one write and one registered read port.
// ----------------------------------------------------------------------------
module mbd_row_ram (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [mbd_pkg::AddrW-1:0] wr_addr,
   input  logic [mbd_pkg::EntryW-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [mbd_pkg::AddrW-1:0] rd_addr,
   output logic [mbd_pkg::EntryW-1:0] rd_data
);

   logic [mbd_pkg::EntryW-1:0] mem [mbd_pkg::StoreDepth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

FILE: design/mipmap_box_downsampler_core.sv
// ----------------------------------------------------------------------------
// mipmap_box_downsampler_core
// Streams base pixels in raster order and emits every coarser mipmap level.
// ----------------------------------------------------------------------------
// Each level visited takes a row store read state, then an add and write state.
// A pixel that emits nothing visits one level; a cascade of k results visits
// k+1 levels, or k when it reaches the last level. A held result stalls it.
// A level's result is registered at the end of its add and write state.
// Synchronous reset: size 10, four channels, all level positions at zero.
// The row store is not cleared; each entry is written before its contents are used.
module mipmap_box_downsampler_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // chan0, chan1, chan2, chan3
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // level, pos_x, pos_y, avg0..avg3, zero fill
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [3:0]  csr_wdata
);

   localparam int AW = mbd_pkg::AddrW;
   localparam int PW = mbd_pkg::PosW;
   localparam int SW = mbd_pkg::SumW;

   typedef enum logic [1:0] {S_IDLE, S_READ, S_CALC} state_type;

   state_type state_ff, state_in;
   logic [3:0] size_ff;
   logic [2:0] chans_ff;
   logic [3:0] lv_ff;
   logic [PW-1:0] col_ff [mbd_pkg::NumLevels];
   logic [PW-1:0] row_ff [mbd_pkg::NumLevels];
   logic [7:0] pix_ff [4];
   logic [7:0] pix_in [4];

   logic rv_ff, rl_ff;
   logic [55:0] rd_ff;

   // effective configuration
   logic [3:0] n_eff;
   logic [2:0] c_eff;
   always_comb begin
      n_eff = size_ff;
      if (n_eff == 4'd0) n_eff = 4'd1;
      if (n_eff > 4'(mbd_pkg::MaxSizeLog2)) n_eff = 4'(mbd_pkg::MaxSizeLog2);
      c_eff = chans_ff;
      if (c_eff == 3'd0) c_eff = 3'd1;
      if (c_eff > 3'd4) c_eff = 3'd4;
   end

   // per level geometry
   logic [PW:0] w, wm1, base;
   logic [PW-1:0] col, row, col_nx, row_nx;
   logic [AW-1:0] idx;
   logic [3:0] lv_up;
   logic first, emit, emit_up, lastlv;
   always_comb begin
      lv_up   = lv_ff + 4'd1;
      w       = (PW+1)'(1) << (n_eff - lv_ff);
      wm1     = w - (PW+1)'(1);
      base    = ((PW+1)'(1) << n_eff) - w;
      col     = col_ff[lv_ff] & wm1[PW-1:0];
      row     = row_ff[lv_ff] & wm1[PW-1:0];
      idx     = base[AW-1:0] + {1'b0, col[PW-1:1]};
      first   = !col[0] && !row[0];
      emit    = col[0] && row[0];
      lastlv  = (lv_up == n_eff);
      // next level emits only at an odd column of an odd row
      emit_up = col_ff[lv_up][0] && row_ff[lv_up][0];
      col_nx  = col + PW'(1);
      row_nx  = row;
      if ({1'b0, col} == wm1) begin
         col_nx = '0;
         row_nx = ({1'b0, row} == wm1) ? '0 : row + PW'(1);
      end
   end

   logic [mbd_pkg::EntryW-1:0] rdata, wdata;
   mbd_pkg::sum_type sum;
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         sum[c] = (first ? SW'(0) : rdata[SW*c +: SW]) + SW'(pix_ff[c]);
         wdata[SW*c +: SW] = sum[c];
         pix_in[c] = sum[c][SW-1:2];
      end
   end

   logic out_free, go, done;
   assign out_free   = !rv_ff || rsp_tready;
   assign go         = (state_ff == S_CALC) && (!emit || out_free);
   assign done       = go && (!emit || lastlv);
   assign req_tready = ((state_ff == S_IDLE) || done) && !csr_we;

   mbd_row_ram u_ram (
      .clock   (clock),
      .wr_en   (go),
      .wr_addr (idx),
      .wr_data (wdata),
      .rd_en   (state_ff == S_READ),
      .rd_addr (idx),
      .rd_data (rdata)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) state_in = S_READ;
         end
         S_READ: state_in = S_CALC;
         S_CALC: begin
            if (done) state_in = (req_tvalid && req_tready) ? S_READ : S_IDLE;
            else if (go) state_in = S_READ;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         size_ff  <= 4'd10;
         chans_ff <= 3'd4;
         lv_ff    <= '0;
         rv_ff    <= 1'b0;
         rl_ff    <= 1'b0;
         for (int i = 0; i < mbd_pkg::NumLevels; i++) begin
            col_ff[i] <= '0;
            row_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_we && csr_index == mbd_pkg::CsrSize) size_ff <= csr_wdata;
         if (csr_we && csr_index == mbd_pkg::CsrChans) chans_ff <= csr_wdata[2:0];
         if (csr_we) begin
            for (int i = 0; i < mbd_pkg::NumLevels; i++) begin
               col_ff[i] <= '0;
               row_ff[i] <= '0;
            end
         end else if (go) begin
            col_ff[lv_ff] <= col_nx;
            row_ff[lv_ff] <= row_nx;
         end
         if (go && emit) begin
            rv_ff <= 1'b1;
            rl_ff <= lastlv || !emit_up;
            rd_ff <= {2'b00, pix_in[3], pix_in[2], pix_in[1], pix_in[0],
                      row[PW-1:1], col[PW-1:1], lv_up};
         end else if (rsp_tready) begin
            rv_ff <= 1'b0;
         end
         if (req_tvalid && req_tready) begin
            lv_ff <= '0;
            for (int c = 0; c < 4; c++) begin
               pix_ff[c] <= (3'(c) < c_eff) ? req_tdata[8*c +: 8] : 8'd0;
            end
         end else if (go && emit && !lastlv) begin
            lv_ff <= lv_up;
            for (int c = 0; c < 4; c++) pix_ff[c] <= pix_in[c];
         end
      end
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rd_ff;
   assign rsp_tlast  = rl_ff;

endmodule

FILE: design/mbd_checker.sv
// ----------------------------------------------------------------------------
// mbd_checker
// Port-level checks for the mipmap box downsampler.
// ----------------------------------------------------------------------------
module mbd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic        rsp_tlast
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   a_level: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[3:0] != 4'd0)
      else $error("level zero emitted");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken back to back");

   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[55:54] == 2'b00)
      else $error("padding not zero");

endmodule

bind mipmap_box_downsampler_core mbd_checker u_mbd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

FILE: dv/mipmap_box_downsampler_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mipmap_box_downsampler_core_tb
// Streams base images through the downsampler and checks every coarser-level
// pixel against a behavioral mipmap chain kept in the bench. The tests cover
// directed corners, clamped register values, image restarts, random images
// under several idle and stall mixes, and a long output hold-off.
// ----------------------------------------------------------------------------
module mipmap_box_downsampler_core_tb;

   typedef struct packed {
      logic [3:0] level;
      logic [8:0] pos_x;
      logic [8:0] pos_y;
      logic [7:0] avg0;
      logic [7:0] avg1;
      logic [7:0] avg2;
      logic [7:0] avg3;
      logic       last;
   } mip_pixel_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;    // chan0, chan1, chan2, chan3
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;    // level, pos_x, pos_y, avg0..avg3, zero fill
   logic        rsp_tlast;
   logic        csr_we;
   logic [0:0]  csr_index;
   logic [3:0]  csr_wdata;

   mip_pixel_type mip_expected_q[$];
   logic [39:0] partial_sums[mbd_pkg::StoreDepth];
   int          src_col[mbd_pkg::NumLevels];
   int          src_row[mbd_pkg::NumLevels];
   logic [3:0]  size_reg;
   logic [2:0]  chans_reg;

   int          send_idle_pct;
   int          recv_stall_pct;
   logic        hold_go = 1'b0;
   int          hold_cnt = 0;
   int          mismatches = 0;
   int          cycles = 0;

   mipmap_box_downsampler_core u_top (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // level positions and clamps of the image chain
   function automatic void restart_image();
      for (int i = 0; i < mbd_pkg::NumLevels; i++) begin
         src_col[i] = 0;
         src_row[i] = 0;
      end
   endfunction

   function automatic void predict_mip_pixels(logic [31:0] d);
      int n, nc, w, col, row, idx, bx, by, cnt;
      int pix[4];
      int sum[4];
      logic [39:0] e;
      bit emit;
      mip_pixel_type r;
      n  = (size_reg == 4'd0) ? 1 :
           ((size_reg > mbd_pkg::MaxSizeLog2) ? mbd_pkg::MaxSizeLog2 : int'(size_reg));
      nc = (chans_reg == 3'd0) ? 1 : ((chans_reg > 3'd4) ? 4 : int'(chans_reg));
      cnt = 0;
      for (int c = 0; c < 4; c++) pix[c] = (c < nc) ? int'(d[8*c +: 8]) : 0;
      for (int lv = 0; lv < n; lv++) begin
         w    = 1 << (n - lv);
         col  = src_col[lv] & (w - 1);
         row  = src_row[lv] & (w - 1);
         idx  = ((1 << n) - w + (col >> 1)) & (mbd_pkg::StoreDepth - 1);
         emit = col[0] && row[0];
         e    = partial_sums[idx];
         for (int c = 0; c < 4; c++)
            sum[c] = (!col[0] && !row[0]) ? pix[c] : (int'(e[10*c +: 10]) + pix[c]);
         for (int c = 0; c < 4; c++) e[10*c +: 10] = sum[c][9:0];
         partial_sums[idx] = e;
         col++;
         if (col == w) begin
            col = 0;
            row++;
            if (row == w) row = 0;
         end
         src_col[lv] = col;
         src_row[lv] = row;
         if (!emit) break;
         bx = (col == 0 ? w : col) - 1;
         by = (col == 0) ? ((row == 0 ? w : row) - 1) : row;
         for (int c = 0; c < 4; c++) pix[c] = (sum[c] >> 2) & 8'hff;
         r.level = 4'(lv + 1);
         r.pos_x = 9'(bx >> 1);
         r.pos_y = 9'(by >> 1);
         r.avg0  = 8'(pix[0]);
         r.avg1  = 8'(pix[1]);
         r.avg2  = 8'(pix[2]);
         r.avg3  = 8'(pix[3]);
         r.last  = 1'b0;
         mip_expected_q = {mip_expected_q, r};
         cnt++;
      end
      if (cnt > 0) mip_expected_q[mip_expected_q.size() - 1].last = 1'b1;
   endfunction

   // ---------------------------------------------------------------- drivers
   task automatic send_pixel(logic [31:0] d);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
      predict_mip_pixels(d);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      wait (mip_expected_q.size() == 0);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_reg(logic [0:0] idx, logic [3:0] val);
      drain();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx == mbd_pkg::CsrSize) size_reg = val;
      else chans_reg = val[2:0];
      restart_image();
      csr_we <= 1'b0;
   endtask

   task automatic send_image(int pixels);
      for (int i = 0; i < pixels; i++) send_pixel($urandom());
   endtask

   // ---------------------------------------------------------------- tests
   task automatic test_reset_defaults();
      // full-size image: the first base row alone yields nothing
      send_image(8);
   endtask

   task automatic test_extreme_pixels();
      write_reg(mbd_pkg::CsrSize, 4'd2);
      write_reg(mbd_pkg::CsrChans, 4'd4);
      for (int i = 0; i < 16; i++) send_pixel(32'hffff_ffff);
      for (int i = 0; i < 16; i++) send_pixel(32'h0000_0000);
      for (int i = 0; i < 8; i++) send_pixel((i % 2) ? 32'hffff_ffff : 32'h0);
   endtask

   task automatic test_clamped_regs();
      write_reg(mbd_pkg::CsrSize, 4'd0);
      write_reg(mbd_pkg::CsrChans, 4'd0);
      for (int i = 0; i < 4; i++) send_pixel($urandom());
      write_reg(mbd_pkg::CsrChans, 4'd15);
      for (int i = 0; i < 8; i++) send_pixel($urandom());
      write_reg(mbd_pkg::CsrSize, 4'd15);
      write_reg(mbd_pkg::CsrChans, 4'd3);
      send_image(16);
   endtask

   task automatic test_restart();
      write_reg(mbd_pkg::CsrSize, 4'd3);
      write_reg(mbd_pkg::CsrChans, 4'd2);
      for (int i = 0; i < 21; i++) send_pixel($urandom());
      write_reg(mbd_pkg::CsrChans, 4'd2);
      for (int i = 0; i < 64; i++) send_pixel($urandom());
   endtask

   task automatic test_random(int idle_pct, int stall_pct);
      int sz;
      int cnt;
      int part;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      cnt = 0;
      while (cnt < 35) begin
         sz = $urandom_range(2, 1);
         write_reg(mbd_pkg::CsrSize, 4'(sz));
         write_reg(mbd_pkg::CsrChans, 4'($urandom_range(15)));
         send_image(1 << (2 * sz));
         cnt += 1 << (2 * sz);
         if ($urandom_range(3) == 0) begin
            part = $urandom_range((1 << (2 * sz)) - 1, 1);
            send_image(part);
            cnt += part;
         end
      end
      drain();
   endtask

   task automatic test_hold_off();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      write_reg(mbd_pkg::CsrSize, 4'd1);
      write_reg(mbd_pkg::CsrChans, 4'd4);
      hold_go <= 1'b1;
      for (int i = 0; i < 40; i++) send_pixel($urandom());
   endtask

   // ---------------------------------------------------------------- receiver
   always @(posedge clock) begin
      if (hold_go && hold_cnt < 200) begin
         hold_cnt   <= hold_cnt + 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      mip_pixel_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.level = rsp_tdata[3:0];
         got.pos_x = rsp_tdata[12:4];
         got.pos_y = rsp_tdata[21:13];
         got.avg0  = rsp_tdata[29:22];
         got.avg1  = rsp_tdata[37:30];
         got.avg2  = rsp_tdata[45:38];
         got.avg3  = rsp_tdata[53:46];
         got.last  = rsp_tlast;
         if (mip_expected_q.size() == 0 || rsp_tdata[55:54] != 2'b00) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected transfer: tdata=%h last=%b", rsp_tdata, rsp_tlast);
         end else begin
            want = mip_expected_q.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: exp lv%0d (%0d,%0d) %h %h %h %h last%b",
                            " got lv%0d (%0d,%0d) %h %h %h %h last%b"},
                     want.level, want.pos_x, want.pos_y, want.avg0, want.avg1,
                     want.avg2, want.avg3, want.last, got.level, got.pos_x,
                     got.pos_y, got.avg0, got.avg1, got.avg2, got.avg3, got.last);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 200000) begin
         $display("mipmap_box_downsampler_core regression: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence
   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      csr_we         = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      size_reg       = 4'd10;
      chans_reg      = 3'd4;
      restart_image();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_extreme_pixels();
      test_clamped_regs();
      test_restart();
      test_random(0, 0);
      test_random(55, 0);
      test_random(0, 55);
      test_random(12, 12);
      test_hold_off();

      req_tvalid <= 1'b0;
      wait (mip_expected_q.size() == 0);
      repeat (50) @(posedge clock);
      if (mismatches == 0 && mip_expected_q.size() == 0)
         $display("mipmap_box_downsampler_core regression: pass");
      else
         $display("mipmap_box_downsampler_core regression: fail");
      $finish;
   end

endmodule
